// ===== sv/tpot_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the trigger pair overlap tracker.
// No dependencies; every other file imports this package.
package tpot_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COL_FULL = 2'd1;
    localparam logic [1:0] ST_PAIR_OVF = 2'd2;
    localparam logic [1:0] ST_NO_EVENT = 2'd3;

    localparam logic [1:0] EV_ENTER = 2'd0;
    localparam logic [1:0] EV_STAY  = 2'd1;
    localparam logic [1:0] EV_EXIT  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        entity_id;
        logic               enabled;
        logic               is_trigger;
        logic               is_sphere;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic [30:0]        radius;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  event_kind;
        logic [31:0] self_entity;
        logic [31:0] other_entity;
        logic [10:0] events_left;
        logic        is_last;
    } t_out_item;

    // A decoded word as it sits in the command queue.
    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_cmd;

endpackage

// ===== sv/tpot_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, decodes the opcode and queues commands.
// Depends on tpot_pkg.
module tpot_front import tpot_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_cmd     o_q_cmd
);

    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp].op   <= t_op'(i_data.opcode);
            r_buf[r_wp].item <= i_data;
        end
    end

endmodule

// ===== sv/tpot_engine.sv =====
`timescale 1ns / 1ps
// Back end: collider store, pair sweep with a shift-add squarer, pair list
// classification against the previous frame, and the event read-out. Uses tpot_pkg.
module tpot_engine import tpot_pkg::*; #(
    parameter int MAX_COLLIDERS = 64,
    parameter int MAX_PAIRS     = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_cmd      i_q_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int CI_W  = $clog2(MAX_COLLIDERS);
    localparam int CC_W  = $clog2(MAX_COLLIDERS + 1);
    localparam int PI_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PC_W  = $clog2(MAX_PAIRS + 1);
    localparam int TOT_W = PC_W + 2;
    localparam int SQ_W  = 33;
    localparam int ACC_W = 68;
    localparam int SQB_W = $clog2(SQ_W);

    typedef enum logic [18:0] {
        S_IDLE    = 19'b0000000000000000001,
        S_I_CHK   = 19'b0000000000000000010,
        S_I_WAIT  = 19'b0000000000000000100,
        S_J_CHK   = 19'b0000000000000001000,
        S_J_WAIT  = 19'b0000000000000010000,
        S_SQ_LOAD = 19'b0000000000000100000,
        S_SQ_RUN  = 19'b0000000000001000000,
        S_SQ_CMP  = 19'b0000000000010000000,
        S_PUSH    = 19'b0000000000100000000,
        S_A_CHK   = 19'b0000000001000000000,
        S_A_WAIT  = 19'b0000000010000000000,
        S_A_SCAN  = 19'b0000000100000000000,
        S_A_CMP   = 19'b0000001000000000000,
        S_B_CHK   = 19'b0000010000000000000,
        S_B_WAIT  = 19'b0000100000000000000,
        S_B_SCAN  = 19'b0001000000000000000,
        S_B_CMP   = 19'b0010000000000000000,
        S_EF_DONE = 19'b0100000000000000000,
        S_EV_WAIT = 19'b1000000000000000000
    } t_state;

    t_state r_state, n_state;
    logic [CC_W-1:0]  r_ccount, n_ccount, r_i, n_i, r_j, n_j;
    logic [1:0]       r_flags, n_flags;
    t_in_item         r_ci, n_ci, r_cj, n_cj;
    logic [1:0]       r_k, n_k;
    logic [ACC_W-1:0] r_mc, n_mc, r_sum, n_sum, r_rsq, n_rsq;
    logic [SQ_W-1:0]  r_mp, n_mp;
    logic [SQB_W-1:0] r_bit, n_bit;
    logic [PC_W-1:0]  r_cc, n_cc, r_pc, n_pc, r_ec, n_ec, r_a, n_a, r_b, n_b;
    logic [63:0]      r_key, n_key;
    logic             r_found, n_found, r_sel, n_sel;
    logic [TOT_W-1:0] r_cursor, n_cursor;
    logic             r_is_cur, n_is_cur, r_odd, n_odd;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_in_item    col_mem [MAX_COLLIDERS];
    logic [63:0] bank0 [MAX_PAIRS];
    logic [63:0] bank1 [MAX_PAIRS];
    logic [63:0] exit_mem [MAX_PAIRS];
    logic        seen_mem [MAX_PAIRS];
    t_in_item    r_col_q;
    logic [63:0] r_q0, r_q1, r_exit_q;
    logic        r_seen_q;

    logic            col_we, cur_we, seen_we, seen_wdata, exit_we;
    logic [CI_W-1:0] col_raddr;
    logic [PI_W-1:0] cur_raddr, prev_raddr, exit_raddr, cur_waddr, seen_waddr, exit_waddr;
    logic [PI_W-1:0] b0_raddr, b1_raddr;
    logic [63:0]     cur_wdata, cur_q, prev_q, ev_key;
    logic [TOT_W-1:0] tot, tot2cc, xe;
    logic            out_free, accept;

    logic signed [31:0] mn_i, mx_i, mn_j, mx_j;
    logic signed [32:0] s_i, s_j;
    logic signed [33:0] d;
    logic [33:0]        ad;
    logic [SQ_W-1:0]    sq_op;
    logic [ACC_W-1:0]   add_in, add_out;
    logic               aabb_hit;

    assign tot2cc   = TOT_W'({r_cc, 1'b0});
    assign tot      = tot2cc + TOT_W'({r_ec, 1'b0});
    assign xe       = r_cursor - tot2cc;
    assign out_free = !r_out_valid || i_ready;
    assign o_q_ready = (r_state == S_IDLE) && out_free;
    assign accept   = i_q_valid && o_q_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign b0_raddr = r_sel ? prev_raddr : cur_raddr;
    assign b1_raddr = r_sel ? cur_raddr : prev_raddr;
    assign cur_q    = r_sel ? r_q1 : r_q0;
    assign prev_q   = r_sel ? r_q0 : r_q1;
    assign ev_key   = r_is_cur ? cur_q : r_exit_q;

    // Sphere operands: doubled centre distance per axis, then doubled radius sum.
    always_comb begin
        unique case (r_k)
            2'd0: begin
                mn_i = r_ci.min_x; mx_i = r_ci.max_x; mn_j = r_cj.min_x; mx_j = r_cj.max_x;
            end
            2'd1: begin
                mn_i = r_ci.min_y; mx_i = r_ci.max_y; mn_j = r_cj.min_y; mx_j = r_cj.max_y;
            end
            default: begin
                mn_i = r_ci.min_z; mx_i = r_ci.max_z; mn_j = r_cj.min_z; mx_j = r_cj.max_z;
            end
        endcase
        s_i = 33'(mn_i) + 33'(mx_i);
        s_j = 33'(mn_j) + 33'(mx_j);
        d   = 34'(s_i) - 34'(s_j);
        ad  = d[33] ? 34'(-d) : 34'(d);
        if (r_k == 2'd3) begin
            sq_op = {32'(r_ci.radius) + 32'(r_cj.radius), 1'b0};
        end else begin
            sq_op = ad[SQ_W-1:0];
        end
        add_in  = (r_k == 2'd3) ? r_rsq : r_sum;
        add_out = add_in + (r_mp[0] ? r_mc : '0);
    end

    assign aabb_hit = (r_ci.min_x <= r_col_q.max_x) && (r_ci.max_x >= r_col_q.min_x) &&
                      (r_ci.min_y <= r_col_q.max_y) && (r_ci.max_y >= r_col_q.min_y) &&
                      (r_ci.min_z <= r_col_q.max_z) && (r_ci.max_z >= r_col_q.min_z);

    always_comb begin
        n_state = r_state;   n_ccount = r_ccount; n_i = r_i;       n_j = r_j;
        n_flags = r_flags;   n_ci = r_ci;         n_cj = r_cj;     n_k = r_k;
        n_mc = r_mc;         n_sum = r_sum;       n_rsq = r_rsq;   n_mp = r_mp;
        n_bit = r_bit;       n_cc = r_cc;         n_pc = r_pc;     n_ec = r_ec;
        n_a = r_a;           n_b = r_b;           n_key = r_key;   n_found = r_found;
        n_sel = r_sel;       n_cursor = r_cursor; n_is_cur = r_is_cur; n_odd = r_odd;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_ready;

        col_we = 1'b0;  cur_we = 1'b0;  seen_we = 1'b0;  exit_we = 1'b0;
        seen_wdata = r_found;
        col_raddr  = r_j[CI_W-1:0];
        cur_raddr  = r_cursor[PI_W:1];
        prev_raddr = r_b[PI_W-1:0];
        exit_raddr = xe[PI_W:1];
        cur_waddr  = r_cc[PI_W-1:0];
        seen_waddr = r_a[PI_W-1:0];
        exit_waddr = r_ec[PI_W-1:0];
        cur_wdata  = (r_ci.entity_id < r_cj.entity_id) ? {r_ci.entity_id, r_cj.entity_id}
                                                       : {r_cj.entity_id, r_ci.entity_id};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_q_cmd.op)
                        OP_LOAD, OP_NOP: begin
                            n_out = '0;
                            n_out.events_left = 11'(tot - r_cursor);
                            n_out_valid = 1'b1;
                            if (i_q_cmd.op == OP_LOAD) begin
                                if (r_ccount < CC_W'(MAX_COLLIDERS)) begin
                                    col_we   = 1'b1;
                                    n_ccount = r_ccount + 1'b1;
                                end else begin
                                    n_flags[0]   = 1'b1;
                                    n_out.status = ST_COL_FULL;
                                end
                            end
                        end
                        OP_END: begin
                            // The current list becomes the previous one by a bank swap.
                            n_sel    = ~r_sel;
                            n_pc     = r_cc;
                            n_cc     = '0;
                            n_ec     = '0;
                            n_cursor = '0;
                            n_i      = '0;
                            n_state  = S_I_CHK;
                        end
                        default: begin
                            if (r_cursor >= tot) begin
                                n_out = '0;
                                n_out.status = ST_NO_EVENT;
                                n_out_valid = 1'b1;
                            end else begin
                                n_is_cur = (r_cursor < tot2cc);
                                n_odd    = r_cursor[0];
                                n_state  = S_EV_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_I_CHK: begin
                col_raddr = r_i[CI_W-1:0];
                if (r_i >= r_ccount) begin
                    n_a = '0;
                    n_state = S_A_CHK;
                end else begin
                    n_state = S_I_WAIT;
                end
            end
            S_I_WAIT: begin
                n_ci = r_col_q;
                if (!r_col_q.enabled) begin
                    n_i = r_i + 1'b1;
                    n_state = S_I_CHK;
                end else begin
                    n_j = r_i + 1'b1;
                    n_state = S_J_CHK;
                end
            end
            S_J_CHK: begin
                if (r_j >= r_ccount) begin
                    n_i = r_i + 1'b1;
                    n_state = S_I_CHK;
                end else begin
                    n_state = S_J_WAIT;
                end
            end
            S_J_WAIT: begin
                n_cj = r_col_q;
                priority if (!r_col_q.enabled || !(r_ci.is_trigger || r_col_q.is_trigger)) begin
                    n_j = r_j + 1'b1;
                    n_state = S_J_CHK;
                end else if (r_ci.is_sphere && r_col_q.is_sphere) begin
                    n_k = 2'd0;
                    n_sum = '0;
                    n_rsq = '0;
                    n_state = S_SQ_LOAD;
                end else if (aabb_hit) begin
                    n_state = S_PUSH;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_J_CHK;
                end
            end
            S_SQ_LOAD: begin
                n_mc  = ACC_W'(sq_op);
                n_mp  = sq_op;
                n_bit = '0;
                n_state = S_SQ_RUN;
            end
            S_SQ_RUN: begin
                // One partial product per cycle, accumulated into the distance sum
                // or into the squared radius term.
                if (r_k == 2'd3) n_rsq = add_out;
                else n_sum = add_out;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_bit = r_bit + 1'b1;
                if (r_bit == SQB_W'(SQ_W - 1)) begin
                    if (r_k == 2'd3) begin
                        n_state = S_SQ_CMP;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_SQ_LOAD;
                    end
                end
            end
            S_SQ_CMP: begin
                if (r_sum <= r_rsq) begin
                    n_state = S_PUSH;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_J_CHK;
                end
            end
            S_PUSH: begin
                if (r_cc < PC_W'(MAX_PAIRS)) begin
                    cur_we = 1'b1;
                    n_cc = r_cc + 1'b1;
                end else begin
                    n_flags[1] = 1'b1;
                end
                n_j = r_j + 1'b1;
                n_state = S_J_CHK;
            end
            S_A_CHK: begin
                cur_raddr = r_a[PI_W-1:0];
                if (r_a >= r_cc) begin
                    n_a = '0;
                    n_ec = '0;
                    n_state = S_B_CHK;
                end else begin
                    n_state = S_A_WAIT;
                end
            end
            S_A_WAIT: begin
                n_key = cur_q;
                n_b = '0;
                n_found = 1'b0;
                n_state = S_A_SCAN;
            end
            S_A_SCAN: begin
                prev_raddr = r_b[PI_W-1:0];
                if (r_b >= r_pc) begin
                    seen_we = 1'b1;
                    n_a = r_a + 1'b1;
                    n_state = S_A_CHK;
                end else begin
                    n_state = S_A_CMP;
                end
            end
            S_A_CMP: begin
                if (prev_q == r_key) n_found = 1'b1;
                n_b = r_b + 1'b1;
                n_state = S_A_SCAN;
            end
            S_B_CHK: begin
                prev_raddr = r_a[PI_W-1:0];
                if (r_a >= r_pc) begin
                    n_state = S_EF_DONE;
                end else begin
                    n_state = S_B_WAIT;
                end
            end
            S_B_WAIT: begin
                n_key = prev_q;
                n_b = '0;
                n_found = 1'b0;
                n_state = S_B_SCAN;
            end
            S_B_SCAN: begin
                cur_raddr = r_b[PI_W-1:0];
                if (r_b >= r_cc) begin
                    // A previous pair missing from this frame is compacted into the exit list.
                    if (!r_found) begin
                        exit_we = 1'b1;
                        n_ec = r_ec + 1'b1;
                    end
                    n_a = r_a + 1'b1;
                    n_state = S_B_CHK;
                end else begin
                    n_state = S_B_CMP;
                end
            end
            S_B_CMP: begin
                if (cur_q == r_key) n_found = 1'b1;
                n_b = r_b + 1'b1;
                n_state = S_B_SCAN;
            end
            S_EF_DONE: begin
                n_out = '0;
                n_out.status = r_flags[1] ? ST_PAIR_OVF : (r_flags[0] ? ST_COL_FULL : ST_OK);
                n_out.events_left = 11'(tot);
                n_out_valid = 1'b1;
                n_flags  = 2'b00;
                n_ccount = '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_out = '0;
                n_out.status = ST_OK;
                n_out.event_kind = r_is_cur ? (r_seen_q ? EV_STAY : EV_ENTER) : EV_EXIT;
                n_out.self_entity  = r_odd ? ev_key[31:0] : ev_key[63:32];
                n_out.other_entity = r_odd ? ev_key[63:32] : ev_key[31:0];
                n_out.events_left  = 11'(tot - r_cursor - 1'b1);
                n_out.is_last      = ((r_cursor + 1'b1) == tot);
                n_out_valid = 1'b1;
                n_cursor = r_cursor + 1'b1;
                n_state  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ccount    <= '0;
            r_flags     <= 2'b00;
            r_cc        <= '0;
            r_pc        <= '0;
            r_ec        <= '0;
            r_sel       <= 1'b0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ccount    <= n_ccount;
            r_flags     <= n_flags;
            r_cc        <= n_cc;
            r_pc        <= n_pc;
            r_ec        <= n_ec;
            r_sel       <= n_sel;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;      r_j <= n_j;      r_ci <= n_ci;    r_cj <= n_cj;
        r_k <= n_k;      r_mc <= n_mc;    r_sum <= n_sum;  r_rsq <= n_rsq;
        r_mp <= n_mp;    r_bit <= n_bit;  r_a <= n_a;      r_b <= n_b;
        r_key <= n_key;  r_found <= n_found;
        r_is_cur <= n_is_cur;  r_odd <= n_odd;  r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (col_we) col_mem[r_ccount[CI_W-1:0]] <= i_q_cmd.item;
        r_col_q <= col_mem[col_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we && !r_sel) bank0[cur_waddr] <= cur_wdata;
        r_q0 <= bank0[b0_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we && r_sel) bank1[cur_waddr] <= cur_wdata;
        r_q1 <= bank1[b1_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
        r_seen_q <= seen_mem[cur_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (exit_we) exit_mem[exit_waddr] <= r_key;
        r_exit_q <= exit_mem[exit_raddr];
    end

    a_pair_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cc <= PC_W'(MAX_PAIRS)) && (r_ec <= r_pc))
        else $error("pair counts out of range");

    a_col_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccount <= CC_W'(MAX_COLLIDERS))
        else $error("collider count out of range");

    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cursor <= tot))
        else $error("event cursor beyond queued events");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EF_DONE) |=> (r_ccount == '0) && (r_flags == 2'b00) && r_out_valid)
        else $error("end of frame did not clear the store or post its word");

endmodule

// ===== sv/trigger_pair_overlap_tracker_top.sv =====
`timescale 1ns / 1ps
// Top level of the trigger pair overlap tracker: command queue plus engine.
// Depends on tpot_pkg, tpot_front and tpot_engine.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_ready   i_data (t_in_item)
//   output    out        o_valid / i_ready   o_data (t_out_item)
//
// Load, no-op and empty reads answer in the cycle after leaving the queue;
// an event read first passes through S_EV_WAIT for its registered pair-memory read.
// End frame time grows with the collider count, the tested pairs and the current
// and previous pair lists, set by the serial pair sweep, the one-bit-a-cycle
// squarer and the linear list scans.
// Reset is synchronous and active low; no clearing pass is needed.
// A two-word queue takes up to two input words while the engine stalls on a full output register.
module trigger_pair_overlap_tracker_top import tpot_pkg::*; #(
    parameter int MAX_COLLIDERS = 64,
    parameter int MAX_PAIRS     = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic q_valid, q_ready;
    t_cmd q_cmd;

    tpot_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_cmd   (q_cmd)
    );

    tpot_engine #(
        .MAX_COLLIDERS (MAX_COLLIDERS),
        .MAX_PAIRS     (MAX_PAIRS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_cmd   (q_cmd),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule
